FILE: rtl/rct_pkg.sv
// Shared types, constants and helper functions of the gradient residual model.
// Used by rct_gradient_residual_model; no dependencies.
package rct_pkg;

  localparam int BIT_DEPTH         = 8;
  localparam int LUMA_LEVELS       = 1 << BIT_DEPTH;
  localparam int CHROMA_LEVELS     = 2 << BIT_DEPTH;
  localparam int CUM_ONE           = 32'h10000;
  localparam int DEF_MAX_WIDTH     = 4096;
  localparam int DEF_RESCALE_LIMIT = 8192;

  // Count store: luma, blue diff, red diff back to back.
  localparam int CNT_DEPTH = LUMA_LEVELS + 2 * CHROMA_LEVELS;
  // Cumulative store: each channel holds levels + 1 entries.
  localparam int CUM_DEPTH = CNT_DEPTH + 3;
  localparam int ADDR_W    = 11;

  localparam logic [1:0] CH_LUMA = 2'd0;
  localparam logic [1:0] CH_BLUE = 2'd1;
  localparam logic [1:0] CH_RED  = 2'd2;

  typedef logic signed [8:0] comp_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  luma_symbol;
    logic [16:0] luma_cum_low;
    logic [16:0] luma_cum_high;
    logic [8:0]  blue_diff_symbol;
    logic [16:0] blue_diff_cum_low;
    logic [16:0] blue_diff_cum_high;
    logic [8:0]  red_diff_symbol;
    logic [16:0] red_diff_cum_low;
    logic [16:0] red_diff_cum_high;
  } out_item_t;

  function automatic logic [ADDR_W-1:0] cnt_base(input logic [1:0] ch);
    case (ch)
      CH_LUMA: cnt_base = ADDR_W'(0);
      CH_BLUE: cnt_base = ADDR_W'(LUMA_LEVELS);
      CH_RED:  cnt_base = ADDR_W'(LUMA_LEVELS + CHROMA_LEVELS);
      default: cnt_base = ADDR_W'(0);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] cum_base(input logic [1:0] ch);
    case (ch)
      CH_LUMA: cum_base = ADDR_W'(0);
      CH_BLUE: cum_base = ADDR_W'(LUMA_LEVELS + 1);
      CH_RED:  cum_base = ADDR_W'(LUMA_LEVELS + CHROMA_LEVELS + 2);
      default: cum_base = ADDR_W'(0);
    endcase
  endfunction

  function automatic logic [9:0] ch_levels(input logic [1:0] ch);
    case (ch)
      CH_LUMA: ch_levels = 10'(LUMA_LEVELS);
      default: ch_levels = 10'(CHROMA_LEVELS);
    endcase
  endfunction

  // Clamp N+W-NW into [min(N,W), max(N,W)].
  function automatic comp_t clamp_grad(input comp_t n, input comp_t w, input comp_t nw);
    logic signed [10:0] p;
    comp_t lo;
    comp_t hi;
    lo = (n < w) ? n : w;
    hi = (n < w) ? w : n;
    p  = 11'(n) + 11'(w) - 11'(nw);
    if (p > 11'(hi)) p = 11'(hi);
    if (p < 11'(lo)) p = 11'(lo);
    clamp_grad = p[8:0];
  endfunction

endpackage

FILE: rtl/rct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rct_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 16-bit quotient.
// Requires dividend[31:16] < divisor. No dependencies.
module rct_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [14:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic [15:0] rem_r;
  logic [15:0] q_r;
  logic [14:0] dv_r;
  logic [4:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;
  logic        take;

  assign trial    = {rem_r, q_r[15]};
  assign take     = trial >= {2'b00, dv_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= dividend[31:16];
        q_r    <= dividend[15:0];
        dv_r   <= divisor;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= take ? 16'(trial - {2'b00, dv_r}) : trial[15:0];
        q_r    <= {q_r[14:0], take};
        step_r <= step_r + 5'd1;
        if (step_r == 5'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/rct_gradient_residual_model.sv
// Gradient residual front end: colour transform, clamped gradient prediction,
// cumulative-frequency lookup and adaptive histograms. Uses rct_pkg, rct_ram, rct_div.
// An item passes prediction, a lookup per channel and the result register; a new item is
// taken only when the last is done; a rescale halves a channel's counts level by level.
// Row end: tables rebuilt through one multiplier and a single divider, level by level (1280
// levels), no item taken meanwhile. Reset: clear max(MAX_WIDTH, 1280) entries, then rebuild.
module rct_gradient_residual_model #(
  parameter int MAX_WIDTH     = rct_pkg::DEF_MAX_WIDTH,
  parameter int RESCALE_LIMIT = rct_pkg::DEF_RESCALE_LIMIT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rct_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rct_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [12:0]         cfg_data
);
  import rct_pkg::*;

  localparam int RAW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CLR_LEN = (MAX_WIDTH > CNT_DEPTH) ? MAX_WIDTH : CNT_DEPTH;
  localparam int CLR_W   = $clog2(CLR_LEN + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PRED, S_LOOK0, S_LOOK1, S_LOOK2, S_RS_RD, S_RS_WR,
    S_OUT, S_RB_RD, S_RB_MUL, S_RB_DIV, S_RB_WAIT, S_RB_END
  } state_t;

  state_t       state_r;
  logic [CLR_W-1:0] clr_r;
  logic [1:0]   ch_r;
  logic [9:0]   k_r;
  logic [RAW-1:0] col_r;
  logic [16:0]  width_r;
  comp_t        w_r [3];
  comp_t        nw_r [3];
  comp_t        cur_r [3];
  logic [8:0]   sym_r [3];
  logic [16:0]  lo_r [3];
  logic [16:0]  hi_r [3];
  logic [14:0]  tot_r [3];
  logic [14:0]  sum_r;
  logic [14:0]  c_r;
  logic [31:0]  prod_r;
  logic         row_end_r;
  logic         out_valid_r;
  out_item_t    out_data_r;

  logic            row_we;
  logic [RAW-1:0]  row_waddr;
  logic [RAW-1:0]  row_raddr;
  logic [26:0]     row_wdata;
  logic [26:0]     row_rdata;
  logic            cnt_we;
  logic [ADDR_W-1:0] cnt_waddr;
  logic [ADDR_W-1:0] cnt_raddr;
  logic [13:0]     cnt_wdata;
  logic [13:0]     cnt_rdata;
  logic            cum_we;
  logic [ADDR_W-1:0] cum_waddr;
  logic [ADDR_W-1:0] cum_raddr;
  logic [16:0]     cum_wdata;
  logic [16:0]     cum_rdata;

  logic            div_start;
  logic            div_done;
  logic [15:0]     div_q;
  logic [14:0]     div_den;

  comp_t           in_cur [3];
  comp_t           north [3];
  comp_t           pred [3];
  comp_t           w_eff [3];
  comp_t           nw_eff [3];
  logic [8:0]      sym_new [3];
  logic [16:0]     width_eff;
  logic [14:0]     half_cnt;
  logic [9:0]      levels;
  logic [16:0]     span;
  logic [8:0]      dr_in;
  logic [8:0]      db_in;
  logic [9:0]      dsum;
  logic [9:0]      y_in;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  assign levels   = ch_levels(ch_r);
  assign span     = 17'(CUM_ONE) - {7'd0, levels};
  assign half_cnt = ({1'b0, cnt_rdata} + 15'd1) >> 1;
  assign div_den  = (tot_r[ch_r] == '0) ? 15'd1 : tot_r[ch_r];

  always_comb begin
    if (width_r == '0) begin
      width_eff = 17'd1;
    end else if (width_r > 17'(MAX_WIDTH)) begin
      width_eff = 17'(MAX_WIDTH);
    end else begin
      width_eff = width_r;
    end
  end

  // Reversible colour transform of the incoming pixel.
  always_comb begin
    dr_in     = 9'({1'b0, in_data.red}) - 9'({1'b0, in_data.green});
    db_in     = 9'({1'b0, in_data.blue}) - 9'({1'b0, in_data.green});
    dsum      = 10'($signed(dr_in)) + 10'($signed(db_in));
    y_in      = 10'({2'b00, in_data.green}) + 10'($signed(dsum) >>> 2);
    in_cur[0] = y_in[8:0];
    in_cur[1] = db_in;
    in_cur[2] = dr_in;
  end

  always_comb begin
    logic signed [10:0] diff;
    north[0] = row_rdata[26:18];
    north[1] = row_rdata[17:9];
    north[2] = row_rdata[8:0];
    for (int i = 0; i < 3; i++) begin
      w_eff[i]  = (col_r == '0) ? comp_t'(0) : w_r[i];
      nw_eff[i] = (col_r == '0) ? comp_t'(0) : nw_r[i];
      pred[i]   = clamp_grad(north[i], w_eff[i], nw_eff[i]);
    end
    diff       = 11'(cur_r[0]) - 11'(pred[0]) + 11'(LUMA_LEVELS >> 1);
    sym_new[0] = {1'b0, diff[7:0]};
    diff       = 11'(cur_r[1]) - 11'(pred[1]) + 11'(LUMA_LEVELS);
    sym_new[1] = diff[8:0];
    diff       = 11'(cur_r[2]) - 11'(pred[2]) + 11'(LUMA_LEVELS);
    sym_new[2] = diff[8:0];
  end

  // Memory port steering.
  always_comb begin
    row_we    = 1'b0;
    row_waddr = col_r;
    row_wdata = {cur_r[0], cur_r[1], cur_r[2]};
    row_raddr = col_r;
    cnt_we    = 1'b0;
    cnt_waddr = cnt_base(ch_r) + ADDR_W'(sym_r[ch_r]);
    cnt_wdata = cnt_rdata + 14'd1;
    cnt_raddr = cnt_base(ch_r) + ADDR_W'(sym_r[ch_r]);
    cum_we    = 1'b0;
    cum_waddr = cum_base(ch_r) + ADDR_W'(k_r);
    cum_wdata = 17'(div_q) + 17'(k_r);
    cum_raddr = cum_base(ch_r) + ADDR_W'(sym_r[ch_r]);
    div_start = 1'b0;
    case (state_r)
      S_CLEAR: begin
        row_we    = (clr_r < CLR_W'(MAX_WIDTH));
        row_waddr = RAW'(clr_r);
        row_wdata = '0;
        cnt_we    = (clr_r < CLR_W'(CNT_DEPTH));
        cnt_waddr = ADDR_W'(clr_r);
        cnt_wdata = 14'd1;
      end
      S_PRED: begin
        row_we = 1'b1;
      end
      S_LOOK1: begin
        cum_raddr = cum_base(ch_r) + ADDR_W'(sym_r[ch_r]) + ADDR_W'(1);
        cnt_we    = 1'b1;
      end
      S_RS_RD, S_RS_WR, S_RB_RD: begin
        cnt_raddr = cnt_base(ch_r) + ADDR_W'(k_r);
        cnt_waddr = cnt_base(ch_r) + ADDR_W'(k_r);
        cnt_wdata = half_cnt[13:0];
        cnt_we    = (state_r == S_RS_WR);
      end
      S_RB_DIV: begin
        div_start = 1'b1;
      end
      S_RB_WAIT: begin
        cum_we = div_done;
      end
      S_RB_END: begin
        cum_we    = 1'b1;
        cum_wdata = 17'(CUM_ONE);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      ch_r        <= CH_LUMA;
      k_r         <= '0;
      col_r       <= '0;
      width_r     <= 17'(MAX_WIDTH);
      tot_r[0]    <= 15'(LUMA_LEVELS);
      tot_r[1]    <= 15'(CHROMA_LEVELS);
      tot_r[2]    <= 15'(CHROMA_LEVELS);
      c_r         <= '0;
      row_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        w_r[i]  <= '0;
        nw_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        width_r <= {4'd0, cfg_data};
      end
      if (out_valid_r && !out_stall && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLR_W'(1);
          if (clr_r == CLR_W'(CLR_LEN - 1)) begin
            ch_r    <= CH_LUMA;
            k_r     <= '0;
            c_r     <= '0;
            state_r <= S_RB_RD;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            for (int i = 0; i < 3; i++) cur_r[i] <= in_cur[i];
            state_r <= S_PRED;
          end
        end
        S_PRED: begin
          for (int i = 0; i < 3; i++) begin
            nw_r[i]  <= north[i];
            w_r[i]   <= cur_r[i];
            sym_r[i] <= sym_new[i];
          end
          if (17'(col_r) + 17'd1 >= width_eff) begin
            row_end_r <= 1'b1;
            col_r     <= '0;
          end else begin
            row_end_r <= 1'b0;
            col_r     <= col_r + RAW'(1);
          end
          ch_r    <= CH_LUMA;
          state_r <= S_LOOK0;
        end
        S_LOOK0: begin
          state_r <= S_LOOK1;
        end
        S_LOOK1: begin
          lo_r[ch_r]  <= cum_rdata;
          tot_r[ch_r] <= tot_r[ch_r] + 15'd1;
          state_r     <= S_LOOK2;
        end
        S_LOOK2: begin
          hi_r[ch_r] <= cum_rdata;
          if (tot_r[ch_r] > 15'(RESCALE_LIMIT)) begin
            k_r     <= '0;
            sum_r   <= '0;
            state_r <= S_RS_RD;
          end else if (ch_r == CH_RED) begin
            state_r <= S_OUT;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_LOOK0;
          end
        end
        S_RS_RD: begin
          state_r <= S_RS_WR;
        end
        S_RS_WR: begin
          sum_r <= sum_r + half_cnt;
          if (k_r == levels - 10'd1) begin
            tot_r[ch_r] <= sum_r + half_cnt;
            if (ch_r == CH_RED) begin
              state_r <= S_OUT;
            end else begin
              ch_r    <= ch_r + 2'd1;
              state_r <= S_LOOK0;
            end
          end else begin
            k_r     <= k_r + 10'd1;
            state_r <= S_RS_RD;
          end
        end
        S_OUT: begin
          // hold until the result register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r                   <= 1'b1;
            out_data_r.luma_symbol        <= sym_r[0][7:0];
            out_data_r.luma_cum_low       <= lo_r[0];
            out_data_r.luma_cum_high      <= hi_r[0];
            out_data_r.blue_diff_symbol   <= sym_r[1];
            out_data_r.blue_diff_cum_low  <= lo_r[1];
            out_data_r.blue_diff_cum_high <= hi_r[1];
            out_data_r.red_diff_symbol    <= sym_r[2];
            out_data_r.red_diff_cum_low   <= lo_r[2];
            out_data_r.red_diff_cum_high  <= hi_r[2];
            if (row_end_r) begin
              ch_r    <= CH_LUMA;
              k_r     <= '0;
              c_r     <= '0;
              state_r <= S_RB_RD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_RB_RD: begin
          state_r <= S_RB_MUL;
        end
        S_RB_MUL: begin
          prod_r  <= 32'(c_r) * 32'(span);
          c_r     <= c_r + 15'(cnt_rdata);
          state_r <= S_RB_DIV;
        end
        S_RB_DIV: begin
          state_r <= S_RB_WAIT;
        end
        S_RB_WAIT: begin
          if (div_done) begin
            if (k_r == levels - 10'd1) begin
              k_r     <= levels;
              state_r <= S_RB_END;
            end else begin
              k_r     <= k_r + 10'd1;
              state_r <= S_RB_RD;
            end
          end
        end
        S_RB_END: begin
          if (ch_r == CH_RED) begin
            state_r <= S_IDLE;
          end else begin
            ch_r    <= ch_r + 2'd1;
            k_r     <= '0;
            c_r     <= '0;
            state_r <= S_RB_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  rct_ram #(.WIDTH(27), .DEPTH(MAX_WIDTH), .AW(RAW)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  rct_ram #(.WIDTH(14), .DEPTH(CNT_DEPTH), .AW(ADDR_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  rct_ram #(.WIDTH(17), .DEPTH(CUM_DEPTH), .AW(ADDR_W)) u_cum_ram (
    .clk   (clk),
    .we    (cum_we),
    .waddr (cum_waddr),
    .wdata (cum_wdata),
    .raddr (cum_raddr),
    .rdata (cum_rdata)
  );

  rct_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod_r),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
